// ----- src/cmc_pkg.sv -----
// Package with the shared types, constants and composition table of the mark composer.
package cmc_pkg;

    localparam int CP_W  = 21;
    localparam int OFF_W = 12;
    localparam int TDATA_W = 40;

    // Default depth of the result queue; at least two results must fit per item.
    localparam int OUT_DEPTH = 4;

    localparam logic [CP_W-1:0] MARK_FIRST = 21'h000300;
    localparam logic [CP_W-1:0] MARK_LAST  = 21'h00036F;

    // Combining marks as offsets from the start of the combining block.
    localparam logic [6:0] MK_GRAVE     = 7'h00;
    localparam logic [6:0] MK_ACUTE     = 7'h01;
    localparam logic [6:0] MK_CIRCUMFLX = 7'h02;
    localparam logic [6:0] MK_TILDE     = 7'h03;
    localparam logic [6:0] MK_BREVE     = 7'h06;
    localparam logic [6:0] MK_DIAERESIS = 7'h08;
    localparam logic [6:0] MK_HOOK      = 7'h09;
    localparam logic [6:0] MK_HORN      = 7'h1B;
    localparam logic [6:0] MK_DOT_BELOW = 7'h23;
    localparam logic [6:0] MK_CEDILLA   = 7'h27;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [OFF_W-1:0] off;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        item_t      first;
        item_t      second;
    } step_t;

    // Precomposed form of base followed by mark, or zero when the pair does not compose.
    function automatic logic [15:0] compose_lookup(input logic [8:0] base,
                                                   input logic [6:0] mark);
        logic [15:0] r;
        r = 16'h0000;
        unique case (mark)
            MK_GRAVE:
            begin
                unique case (base)
                    9'h041: r = 16'h00C0; 9'h045: r = 16'h00C8; 9'h049: r = 16'h00CC;
                    9'h04F: r = 16'h00D2; 9'h055: r = 16'h00D9; 9'h061: r = 16'h00E0;
                    9'h065: r = 16'h00E8; 9'h069: r = 16'h00EC; 9'h06F: r = 16'h00F2;
                    9'h075: r = 16'h00F9; 9'h0C2: r = 16'h1EA6; 9'h0E2: r = 16'h1EA7;
                    9'h0CA: r = 16'h1EC0; 9'h0EA: r = 16'h1EC1; 9'h0D4: r = 16'h1ED2;
                    9'h0F4: r = 16'h1ED3; 9'h102: r = 16'h1EB0; 9'h103: r = 16'h1EB1;
                    9'h1A0: r = 16'h1EDC; 9'h1A1: r = 16'h1EDD; 9'h1AF: r = 16'h1EEA;
                    9'h1B0: r = 16'h1EEB;
                    default: r = 16'h0000;
                endcase
            end
            MK_ACUTE:
            begin
                unique case (base)
                    9'h041: r = 16'h00C1; 9'h045: r = 16'h00C9; 9'h049: r = 16'h00CD;
                    9'h04F: r = 16'h00D3; 9'h055: r = 16'h00DA; 9'h059: r = 16'h00DD;
                    9'h061: r = 16'h00E1; 9'h065: r = 16'h00E9; 9'h069: r = 16'h00ED;
                    9'h06F: r = 16'h00F3; 9'h075: r = 16'h00FA; 9'h079: r = 16'h00FD;
                    9'h0C2: r = 16'h1EA4; 9'h0E2: r = 16'h1EA5; 9'h0CA: r = 16'h1EBE;
                    9'h0EA: r = 16'h1EBF; 9'h0D4: r = 16'h1ED0; 9'h0F4: r = 16'h1ED1;
                    9'h102: r = 16'h1EAE; 9'h103: r = 16'h1EAF; 9'h1A0: r = 16'h1EDA;
                    9'h1A1: r = 16'h1EDB; 9'h1AF: r = 16'h1EE8; 9'h1B0: r = 16'h1EE9;
                    default: r = 16'h0000;
                endcase
            end
            MK_CIRCUMFLX:
            begin
                unique case (base)
                    9'h041: r = 16'h00C2; 9'h045: r = 16'h00CA; 9'h049: r = 16'h00CE;
                    9'h04F: r = 16'h00D4; 9'h055: r = 16'h00DB; 9'h061: r = 16'h00E2;
                    9'h065: r = 16'h00EA; 9'h069: r = 16'h00EE; 9'h06F: r = 16'h00F4;
                    9'h075: r = 16'h00FB;
                    default: r = 16'h0000;
                endcase
            end
            MK_TILDE:
            begin
                unique case (base)
                    9'h041: r = 16'h00C3; 9'h04E: r = 16'h00D1; 9'h04F: r = 16'h00D5;
                    9'h061: r = 16'h00E3; 9'h06E: r = 16'h00F1; 9'h06F: r = 16'h00F5;
                    9'h0C2: r = 16'h1EAA; 9'h0E2: r = 16'h1EAB; 9'h0CA: r = 16'h1EC4;
                    9'h0EA: r = 16'h1EC5; 9'h0D4: r = 16'h1ED6; 9'h0F4: r = 16'h1ED7;
                    9'h102: r = 16'h1EB4; 9'h103: r = 16'h1EB5; 9'h1A0: r = 16'h1EE0;
                    9'h1A1: r = 16'h1EE1; 9'h1AF: r = 16'h1EEE; 9'h1B0: r = 16'h1EEF;
                    default: r = 16'h0000;
                endcase
            end
            MK_BREVE:
            begin
                unique case (base)
                    9'h041: r = 16'h0102; 9'h061: r = 16'h0103;
                    default: r = 16'h0000;
                endcase
            end
            MK_DIAERESIS:
            begin
                unique case (base)
                    9'h041: r = 16'h00C4; 9'h045: r = 16'h00CB; 9'h049: r = 16'h00CF;
                    9'h04F: r = 16'h00D6; 9'h055: r = 16'h00DC; 9'h061: r = 16'h00E4;
                    9'h065: r = 16'h00EB; 9'h069: r = 16'h00EF; 9'h06F: r = 16'h00F6;
                    9'h075: r = 16'h00FC; 9'h079: r = 16'h00FF;
                    default: r = 16'h0000;
                endcase
            end
            MK_HOOK:
            begin
                unique case (base)
                    9'h041: r = 16'h1EA2; 9'h061: r = 16'h1EA3; 9'h045: r = 16'h1EBA;
                    9'h065: r = 16'h1EBB; 9'h049: r = 16'h1EC8; 9'h069: r = 16'h1EC9;
                    9'h04F: r = 16'h1ECE; 9'h06F: r = 16'h1ECF; 9'h055: r = 16'h1EE6;
                    9'h075: r = 16'h1EE7; 9'h059: r = 16'h1EF6; 9'h079: r = 16'h1EF7;
                    9'h0C2: r = 16'h1EA8; 9'h0E2: r = 16'h1EA9; 9'h0CA: r = 16'h1EC2;
                    9'h0EA: r = 16'h1EC3; 9'h0D4: r = 16'h1ED4; 9'h0F4: r = 16'h1ED5;
                    9'h102: r = 16'h1EB2; 9'h103: r = 16'h1EB3; 9'h1A0: r = 16'h1EDE;
                    9'h1A1: r = 16'h1EDF; 9'h1AF: r = 16'h1EEC; 9'h1B0: r = 16'h1EED;
                    default: r = 16'h0000;
                endcase
            end
            MK_HORN:
            begin
                unique case (base)
                    9'h04F: r = 16'h01A0; 9'h06F: r = 16'h01A1; 9'h055: r = 16'h01AF;
                    9'h075: r = 16'h01B0;
                    default: r = 16'h0000;
                endcase
            end
            MK_DOT_BELOW:
            begin
                unique case (base)
                    9'h041: r = 16'h1EA0; 9'h061: r = 16'h1EA1; 9'h045: r = 16'h1EB8;
                    9'h065: r = 16'h1EB9; 9'h049: r = 16'h1ECA; 9'h069: r = 16'h1ECB;
                    9'h04F: r = 16'h1ECC; 9'h06F: r = 16'h1ECD; 9'h055: r = 16'h1EE4;
                    9'h075: r = 16'h1EE5; 9'h059: r = 16'h1EF4; 9'h079: r = 16'h1EF5;
                    9'h0C2: r = 16'h1EAC; 9'h0E2: r = 16'h1EAD; 9'h0CA: r = 16'h1EC6;
                    9'h0EA: r = 16'h1EC7; 9'h0D4: r = 16'h1ED8; 9'h0F4: r = 16'h1ED9;
                    9'h102: r = 16'h1EB6; 9'h103: r = 16'h1EB7; 9'h1A0: r = 16'h1EE2;
                    9'h1A1: r = 16'h1EE3; 9'h1AF: r = 16'h1EF0; 9'h1B0: r = 16'h1EF1;
                    default: r = 16'h0000;
                endcase
            end
            MK_CEDILLA:
            begin
                unique case (base)
                    9'h043: r = 16'h00C7; 9'h063: r = 16'h00E7;
                    default: r = 16'h0000;
                endcase
            end
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

// ----- src/combining_mark_composer_unit.sv -----
// Top level of the combining mark composer: input register, composition step and result queue.
//
// Input transfers on s_tvalid/s_tready carry one decoded code point with its byte
// offset; s_tlast marks the last code point of a word. A combining mark that
// follows a held code point is merged into it when a precomposed form exists, and
// such merges chain. Results leave on m_tvalid/m_tready, with m_tlast on the last
// code point of the word.
// One input transfer can be taken in every cycle while the queue has room. A transfer is
// registered, then composed against the held code point once the queue has room, and
// its results reach the queue at the end of that cycle. One input can release two
// results; the queue absorbs them while the output runs at one transfer per cycle.
// When the receiver stalls, the queue fills and s_tready falls once fewer than two
// free places remain; nothing is lost. Reset empties the queue and drops any held
// code point; the block is ready in the first cycle after reset.
module combining_mark_composer_unit #(
    parameter int OUT_DEPTH = cmc_pkg::OUT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cmc_pkg::TDATA_W-1:0] s_tdata,  // codepoint[20:0], byte_offset[32:21], zeros
    input  logic                        s_tlast,  // word_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cmc_pkg::TDATA_W-1:0] m_tdata,  // out_codepoint[20:0], out_offset[32:21], zeros
    output logic                        m_tlast   // out_last
);
    import cmc_pkg::*;

    logic             s1_valid_reg;
    logic [CP_W-1:0]  s1_cp_reg;
    logic [OFF_W-1:0] s1_off_reg;
    logic             s1_end_reg;
    logic             room;
    logic             fire;
    item_t            s1_item;
    step_t            step;
    item_t            head;

    assign fire     = s1_valid_reg && room;
    assign s_tready = !s1_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_cp_reg  <= s_tdata[CP_W-1:0];
            s1_off_reg <= s_tdata[CP_W+OFF_W-1:CP_W];
            s1_end_reg <= s_tlast;
        end
    end

    assign s1_item.cp   = s1_cp_reg;
    assign s1_item.off  = s1_off_reg;
    assign s1_item.last = s1_end_reg;

    cmc_compose u_compose (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s1_item),
        .step  (step)
    );

    cmc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fire),
        .step     (step),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = {{(TDATA_W-CP_W-OFF_W){1'b0}}, head.off, head.cp};
    assign m_tlast = head.last;

endmodule

// ----- src/cmc_compose.sv -----
// Composition step: the held code point register and the logic that merges marks into it.
module cmc_compose (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  cmc_pkg::item_t item,
    output cmc_pkg::step_t step
);
    import cmc_pkg::*;

    logic             pend_valid_reg, pend_valid_next;
    logic [CP_W-1:0]  pend_cp_reg, pend_cp_next;
    logic [OFF_W-1:0] pend_off_reg, pend_off_next;

    logic        is_mark;
    logic [15:0] composed;
    logic        hit;
    logic        emit_held;
    item_t       held_item;
    item_t       final_item;

    assign is_mark = pend_valid_reg && (item.cp >= MARK_FIRST) && (item.cp <= MARK_LAST)
                     && (pend_cp_reg[CP_W-1:9] == '0);
    assign composed = compose_lookup(pend_cp_reg[8:0], item.cp[6:0]);
    assign hit = is_mark && (composed != 16'h0000);
    assign emit_held = pend_valid_reg && !hit;

    always_comb
    begin
        held_item.cp   = pend_cp_reg;
        held_item.off  = pend_off_reg;
        held_item.last = 1'b0;

        if (hit)
        begin
            final_item.cp  = {{(CP_W-16){1'b0}}, composed};
            final_item.off = pend_off_reg;
        end
        else
        begin
            final_item.cp  = item.cp;
            final_item.off = item.off;
        end
        final_item.last = 1'b1;

        step.count  = {1'b0, emit_held} + {1'b0, item.last};
        step.first  = emit_held ? held_item : final_item;
        step.second = final_item;

        pend_valid_next = !item.last;
        pend_cp_next    = item.last ? '0 : final_item.cp;
        pend_off_next   = item.last ? '0 : final_item.off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_cp_reg    <= '0;
            pend_off_reg   <= '0;
        end
        else if (fire)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_cp_reg    <= pend_cp_next;
            pend_off_reg   <= pend_off_next;
        end
    end

    // A word end always leaves nothing held.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> !pend_valid_reg)
        else $error("held code point survived the end of a word");

    // A composition keeps the offset of the base that began it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && hit && !item.last |=> pend_valid_reg && $stable(pend_off_reg))
        else $error("composition changed the base offset");

endmodule

// ----- src/cmc_out_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one per transfer.
module cmc_out_fifo #(
    parameter int DEPTH = cmc_pkg::OUT_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmc_pkg::step_t step,
    output logic           room,
    output logic           m_tvalid,
    input  logic           m_tready,
    output cmc_pkg::item_t head
);
    import cmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic [1:0]       n_push;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign n_push   = push ? step.count : 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= step.first;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_1] <= step.second;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflowed");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("results pushed without room for two");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && step.count != 2'd0 |=> m_tvalid)
        else $error("pushed result not offered");

endmodule
